FILE: hw/rtl/hmdd_pkg.sv
// ----------------------------------------------------------------------------
// hmdd_pkg
// Shared constants, types and register codes of the heightmap delta decoder.
// ----------------------------------------------------------------------------
package hmdd_pkg;

	localparam int GRID_POINTS = 33;
	localparam int QUAD_POINTS = 17;
	localparam int QUAD_HALF   = QUAD_POINTS - 1;
	localparam int CNT_W       = $clog2(GRID_POINTS);
	localparam int NUM_QUADS   = 4;
	localparam int QUAD_W      = 2;
	localparam int VIDX_W      = 9;
	localparam int HEIGHT_FRAC = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int BASE_W      = 25;
	localparam int OFF_W       = CNT_W + 12;

	localparam logic [15:0] CELL_SIZE_RST    = 16'd4096;
	localparam logic [11:0] GRID_STEP_RST    = 12'd128;
	localparam logic [15:0] HEIGHT_SCALE_RST = 16'd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_X       = 3'd0,
		CFG_TILE_Y       = 3'd1,
		CFG_CELL_SIZE    = 3'd2,
		CFG_GRID_STEP    = 3'd3,
		CFG_HEIGHT_SCALE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic signed [31:0] acc;
	} entry_t;

	typedef struct packed {
		logic signed [BASE_W-1:0] base_x;
		logic signed [BASE_W-1:0] base_y;
		logic [11:0] grid_step;
		logic [15:0] height_scale;
	} cfg_t;

endpackage

FILE: hw/rtl/hmdd_in_if.sv
// ----------------------------------------------------------------------------
// hmdd_in_if
// Input channel: one signed height delta per grid point plus tile base.
// ----------------------------------------------------------------------------
interface hmdd_in_if;
	logic valid;
	logic ready;
	logic signed [7:0] delta;
	logic signed [31:0] base_offset;

	modport source(output valid, delta, base_offset, input ready);
	modport sink(input valid, delta, base_offset, output ready);
endinterface

FILE: hw/rtl/hmdd_out_if.sv
// ----------------------------------------------------------------------------
// hmdd_out_if
// Result channel: one vertex of one quadrant per beat.
// ----------------------------------------------------------------------------
interface hmdd_out_if;
	logic valid;
	logic ready;
	logic [1:0] quadrant;
	logic [8:0] vertex_index;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [47:0] height;
	logic last;

	modport source(output valid, quadrant, vertex_index, pos_x, pos_y, height, last,
		input ready);
	modport sink(input valid, quadrant, vertex_index, pos_x, pos_y, height, last,
		output ready);
endinterface

FILE: hw/rtl/hmdd_front.sv
// ----------------------------------------------------------------------------
// hmdd_front
// Accepts delta beats, tracks row and column, rebuilds the saturating height.
// ----------------------------------------------------------------------------
module hmdd_front (
	input  logic            clk,
	input  logic            arst_n,
	hmdd_in_if.sink         item,
	input  logic            q_full,
	output logic            q_push,
	output hmdd_pkg::entry_t q_entry
);

	logic [hmdd_pkg::CNT_W-1:0] row_q;
	logic [hmdd_pkg::CNT_W-1:0] col_q;
	logic signed [31:0] row_start_q;
	logic signed [31:0] running_q;
	logic signed [31:0] row_start_n;
	logic signed [31:0] acc_n;
	logic signed [16:0] step;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
		logic signed [16:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;
	assign step       = 17'($signed({item.delta, 8'b0}));

	always_comb begin
		row_start_n = row_start_q;
		acc_n       = sat_add(running_q, step);
		if (col_q == '0) begin
			if (row_q == '0) begin
				row_start_n = item.base_offset;
			end else begin
				row_start_n = sat_add(row_start_q, step);
			end
			acc_n = row_start_n;
		end
	end

	assign q_entry.row = row_q;
	assign q_entry.col = col_q;
	assign q_entry.acc = acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			row_start_q <= '0;
			running_q   <= '0;
		end else if (q_push) begin
			row_start_q <= row_start_n;
			running_q   <= acc_n;
			if (col_q == hmdd_pkg::CNT_W'(hmdd_pkg::GRID_POINTS - 1)) begin
				col_q <= '0;
				if (row_q == hmdd_pkg::CNT_W'(hmdd_pkg::GRID_POINTS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/hmdd_queue.sv
// ----------------------------------------------------------------------------
// hmdd_queue
// Short entry queue between the front and the back.
// ----------------------------------------------------------------------------
module hmdd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hmdd_pkg::entry_t wr_entry,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output hmdd_pkg::entry_t rd_entry
);

	hmdd_pkg::entry_t mem_q [hmdd_pkg::QUEUE_DEPTH];
	logic [hmdd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hmdd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hmdd_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full     = count_q == hmdd_pkg::QCNT_W'(hmdd_pkg::QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == hmdd_pkg::QPTR_W'(hmdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == hmdd_pkg::QPTR_W'(hmdd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/hmdd_back.sv
// ----------------------------------------------------------------------------
// hmdd_back
// Scales position and height, then emits one beat per containing quadrant.
// ----------------------------------------------------------------------------
module hmdd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hmdd_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  hmdd_pkg::entry_t q_entry,
	output logic             q_pop,
	hmdd_out_if.source       result
);

	localparam int NQ = hmdd_pkg::NUM_QUADS;

	logic valid_s1;
	logic [hmdd_pkg::OFF_W-1:0] offx_s1;
	logic [hmdd_pkg::OFF_W-1:0] offy_s1;
	logic signed [47:0] prod_s1;
	logic [NQ-1:0] mask_s1;
	logic [hmdd_pkg::VIDX_W-1:0] vidx_s1 [NQ];

	logic valid_s2;
	logic [NQ-1:0] mask_s2;
	logic [hmdd_pkg::VIDX_W-1:0] vidx_s2 [NQ];
	logic [31:0] px_s2;
	logic [31:0] py_s2;
	logic signed [47:0] h_s2;

	logic [NQ-1:0] mask_n;
	logic [hmdd_pkg::VIDX_W-1:0] vidx_n [NQ];
	logic [hmdd_pkg::CNT_W-1:0] r0;
	logic [hmdd_pkg::CNT_W-1:0] c0;
	logic [hmdd_pkg::CNT_W-1:0] lr;
	logic [hmdd_pkg::CNT_W-1:0] lc;
	logic signed [48:0] prod_full;
	logic [hmdd_pkg::QUAD_W-1:0] cur_q;
	logic [NQ-1:0] mask_rest;
	logic out_fire;
	logic s2_free;
	logic s1_take;

	// quadrant membership and local vertex index
	always_comb begin
		r0 = '0;
		c0 = '0;
		lr = '0;
		lc = '0;
		for (int q = 0; q < NQ; q++) begin
			r0 = ((q / 2) % 2 == 1) ? hmdd_pkg::CNT_W'(hmdd_pkg::QUAD_HALF) : '0;
			c0 = (q % 2 == 1) ? hmdd_pkg::CNT_W'(hmdd_pkg::QUAD_HALF) : '0;
			lr = q_entry.row - r0;
			lc = q_entry.col - c0;
			mask_n[q] = (q_entry.row >= r0) && (lr < hmdd_pkg::CNT_W'(hmdd_pkg::QUAD_POINTS)) &&
				(q_entry.col >= c0) && (lc < hmdd_pkg::CNT_W'(hmdd_pkg::QUAD_POINTS));
			vidx_n[q] = hmdd_pkg::VIDX_W'(lr) * hmdd_pkg::VIDX_W'(hmdd_pkg::QUAD_POINTS) +
				hmdd_pkg::VIDX_W'(lc);
		end
	end

	assign prod_full = 49'(q_entry.acc) * 49'($signed({1'b0, cfg.height_scale}));

	always_comb begin
		cur_q = '0;
		for (int q = NQ - 1; q >= 0; q--) begin
			if (mask_s2[q]) begin
				cur_q = hmdd_pkg::QUAD_W'(q);
			end
		end
	end

	assign mask_rest = mask_s2 & (mask_s2 - NQ'(1));
	assign out_fire  = valid_s2 && result.ready;
	assign s2_free   = !valid_s2 || (out_fire && (mask_rest == '0));
	assign s1_take   = !valid_s1 || s2_free;
	assign q_pop     = q_valid && s1_take;

	assign result.valid        = valid_s2;
	assign result.quadrant     = cur_q;
	assign result.vertex_index = vidx_s2[cur_q];
	assign result.pos_x        = px_s2;
	assign result.pos_y        = py_s2;
	assign result.height       = h_s2;
	assign result.last         = mask_rest == '0;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			offx_s1 <= hmdd_pkg::OFF_W'(q_entry.col) * hmdd_pkg::OFF_W'(cfg.grid_step);
			offy_s1 <= hmdd_pkg::OFF_W'(q_entry.row) * hmdd_pkg::OFF_W'(cfg.grid_step);
			prod_s1 <= prod_full[47:0];
			mask_s1 <= mask_n;
			vidx_s1 <= vidx_n;
		end
		if (valid_s1 && s2_free) begin
			px_s2   <= 32'(cfg.base_x) + 32'(offx_s1);
			py_s2   <= 32'(cfg.base_y) + 32'(offy_s1);
			h_s2    <= prod_s1 >>> hmdd_pkg::HEIGHT_FRAC;
			vidx_s2 <= vidx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else begin
			if (s1_take) begin
				valid_s1 <= q_valid;
			end
			if (valid_s1 && s2_free) begin
				valid_s2 <= mask_s1 != '0;
				mask_s2  <= mask_s1;
			end else if (out_fire) begin
				mask_s2  <= mask_rest;
				valid_s2 <= mask_rest != '0;
			end
		end
	end

endmodule

FILE: hw/rtl/heightmap_delta_decode_split_unit.sv
// ----------------------------------------------------------------------------
// heightmap_delta_decode_split_unit
// Rebuilds a delta coded height tile and splits it into four quadrants.
// ----------------------------------------------------------------------------
// path: a taken input beat passes the queue, scaling stage and output stage
// throughput: one input beat per cycle while the queue is not full; one result
//   beat per cycle while ready, two for a point on a shared edge, four for the
//   centre (1156 per 1089-point tile), the 4-entry queue absorbing the stall
// reset: row/column counters and heights clear, queue and stages empty,
//   registers take their default values
module heightmap_delta_decode_split_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	hmdd_in_if.sink                         item,
	hmdd_out_if.source                      result,
	input  logic                            cfg_we,
	input  logic [hmdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic signed [7:0] tile_x_q;
	logic signed [7:0] tile_y_q;
	logic [15:0] cell_size_q;
	logic [11:0] grid_step_q;
	logic [15:0] height_scale_q;
	logic signed [hmdd_pkg::BASE_W-1:0] base_x_q;
	logic signed [hmdd_pkg::BASE_W-1:0] base_y_q;
	hmdd_pkg::cfg_t cfg;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	hmdd_pkg::entry_t wr_entry;
	hmdd_pkg::entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_x_q       <= '0;
			tile_y_q       <= '0;
			cell_size_q    <= hmdd_pkg::CELL_SIZE_RST;
			grid_step_q    <= hmdd_pkg::GRID_STEP_RST;
			height_scale_q <= hmdd_pkg::HEIGHT_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmdd_pkg::CFG_TILE_X:       tile_x_q       <= cfg_wdata[7:0];
				hmdd_pkg::CFG_TILE_Y:       tile_y_q       <= cfg_wdata[7:0];
				hmdd_pkg::CFG_CELL_SIZE:    cell_size_q    <= cfg_wdata[15:0];
				hmdd_pkg::CFG_GRID_STEP:    grid_step_q    <= cfg_wdata[11:0];
				hmdd_pkg::CFG_HEIGHT_SCALE: height_scale_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// tile origin, refreshed every cycle from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
		end else begin
			base_x_q <= hmdd_pkg::BASE_W'(tile_x_q) *
				hmdd_pkg::BASE_W'($signed({1'b0, cell_size_q}));
			base_y_q <= hmdd_pkg::BASE_W'(tile_y_q) *
				hmdd_pkg::BASE_W'($signed({1'b0, cell_size_q}));
		end
	end

	assign cfg.base_x       = base_x_q;
	assign cfg.base_y       = base_y_q;
	assign cfg.grid_step    = grid_step_q;
	assign cfg.height_scale = height_scale_q;

	hmdd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	hmdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.rd_entry (rd_entry)
	);

	hmdd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.result  (result)
	);

	a_quad_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=>
			result.valid && (result.quadrant > $past(result.quadrant)))
		else $error("quadrants of one point out of order");

	a_vidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.vertex_index <
			hmdd_pkg::VIDX_W'(hmdd_pkg::QUAD_POINTS * hmdd_pkg::QUAD_POINTS))
		else $error("vertex index outside quadrant");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item.ready) |-> $past(item.valid))
		else $error("queue filled without an input beat");

endmodule
